### design/bht_pkg.sv
package bht_pkg;

  localparam int MAX_BONES_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;

  localparam int ELEM_W    = 32;
  localparam int ACC_W     = 66;  // sum of four 64-bit products plus two carry bits
  localparam int NUM_LANES = 4;
  localparam int BONE_W    = 8;
  localparam int PAR_W     = 9;
  localparam int ROW_W     = 2;
  localparam int OQ_DEPTH  = 4;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [NUM_LANES-1:0][ELEM_W-1:0] row_vec_t;

  localparam acc_t SAT_HI = {{(ACC_W-ELEM_W){1'b0}}, 32'h7fff_ffff};
  localparam acc_t SAT_LO = {{(ACC_W-ELEM_W){1'b1}}, 32'h8000_0000};

  typedef struct packed {
    logic              mul_en;
    logic              acc_en;
    logic              first;
  } lane_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0]  beat;
    logic [BONE_W-1:0] bone;
    logic [ROW_W-1:0]  row;
    logic              fwd;
    logic              wr;
  } beat_t;

  typedef struct packed {
    logic [BONE_W-1:0] bone;
    logic [ROW_W-1:0]  row;
    row_vec_t          elems;
    logic              fwd;
    logic              sat;
  } res_t;

endpackage

### design/bht_lane.sv
module bht_lane (
  input  logic                clk_i,
  input  bht_pkg::lane_ctl_t  ctl_i,
  input  bht_pkg::elem_t      a_i,
  input  bht_pkg::elem_t      b_i,
  output bht_pkg::acc_t       acc_o
);

  logic signed [2*bht_pkg::ELEM_W-1:0] prod_q;
  bht_pkg::acc_t                       prod_ext;
  bht_pkg::acc_t                       acc_q;

  assign prod_ext = {{(bht_pkg::ACC_W-2*bht_pkg::ELEM_W){prod_q[2*bht_pkg::ELEM_W-1]}},
                     prod_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    if (ctl_i.acc_en) begin
      acc_q <= ctl_i.first ? prod_ext : acc_q + prod_ext;
    end
  end

  assign acc_o = acc_q;

endmodule

### design/bht_merge.sv
module bht_merge #(
  parameter int FRAC_BITS = bht_pkg::FRAC_BITS_DEF
) (
  input  bht_pkg::acc_t    acc_i [bht_pkg::NUM_LANES],
  output bht_pkg::row_vec_t comb_o,
  output logic             sat_o
);

  bht_pkg::acc_t                  sh [bht_pkg::NUM_LANES];
  logic [bht_pkg::NUM_LANES-1:0]  clip;

  always_comb begin
    for (int j = 0; j < bht_pkg::NUM_LANES; j++) begin
      sh[j] = acc_i[j] >>> FRAC_BITS;
      if (sh[j] > bht_pkg::SAT_HI) begin
        comb_o[j] = 32'h7fff_ffff;
        clip[j]   = 1'b1;
      end else if (sh[j] < bht_pkg::SAT_LO) begin
        comb_o[j] = 32'h8000_0000;
        clip[j]   = 1'b1;
      end else begin
        comb_o[j] = sh[j][bht_pkg::ELEM_W-1:0];
        clip[j]   = 1'b0;
      end
    end
  end

  assign sat_o = |clip;

endmodule

### design/bht_outq.sv
module bht_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bht_pkg::res_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bht_pkg::res_t  data_o
);

  localparam int PW = $clog2(bht_pkg::OQ_DEPTH);
  localparam int CW = $clog2(bht_pkg::OQ_DEPTH + 1);

  bht_pkg::res_t  store_q [bht_pkg::OQ_DEPTH];
  logic [PW-1:0]  head_q, tail_q;
  logic [CW-1:0]  cnt_q;
  logic           pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = store_q[head_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        tail_q <= tail_q + 1'b1;
      end
      if (pop) begin
        head_q <= head_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[tail_q] <= data_i;
    end
  end

endmodule

### design/bone_hierarchy_transform.sv
// Each word reads its parent's four stored rows one per cycle from the single-read-port
// combined table; the next word is accepted only as the last of these reads goes out.
// A word whose parent's matrix is still being written back waits for the write.
// Reset: async active low; a clearing pass then writes identity into the table,
// with in_ready_o held low.
module bone_hierarchy_transform #(
  parameter int MAX_BONES = bht_pkg::MAX_BONES_DEF,
  parameter int FRAC_BITS = bht_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bht_pkg::BONE_W-1:0]         bone_index_i,
  input  logic signed [bht_pkg::PAR_W-1:0]   parent_index_i,
  input  logic [bht_pkg::ROW_W-1:0]          row_index_i,
  input  logic signed [bht_pkg::ELEM_W-1:0]  local_e0_i,
  input  logic signed [bht_pkg::ELEM_W-1:0]  local_e1_i,
  input  logic signed [bht_pkg::ELEM_W-1:0]  local_e2_i,
  input  logic signed [bht_pkg::ELEM_W-1:0]  local_e3_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bht_pkg::BONE_W-1:0]         out_bone_o,
  output logic [bht_pkg::ROW_W-1:0]          out_row_o,
  output logic signed [bht_pkg::ELEM_W-1:0]  comb_e0_o,
  output logic signed [bht_pkg::ELEM_W-1:0]  comb_e1_o,
  output logic signed [bht_pkg::ELEM_W-1:0]  comb_e2_o,
  output logic signed [bht_pkg::ELEM_W-1:0]  comb_e3_o,
  output logic                               forward_parent_o,
  output logic                               saturated_o
);

  localparam int BIDX_W = $clog2(MAX_BONES);
  localparam int AW     = BIDX_W + 2;
  localparam int DEPTH  = MAX_BONES * 4;
  localparam int CW     = $clog2(bht_pkg::OQ_DEPTH + 1);
  localparam logic [bht_pkg::ELEM_W-1:0] ONE = 32'd1 << FRAC_BITS;

  function automatic bht_pkg::row_vec_t ident_row(input logic [1:0] r);
    bht_pkg::row_vec_t v;
    v    = '0;
    v[r] = ONE;
    return v;
  endfunction

  // Issue register: holds the accepted word while its four table reads go out.
  logic                             ir_v_q;
  logic [bht_pkg::BONE_W-1:0]       ir_bone_q;
  logic [bht_pkg::PAR_W-1:0]        ir_par_q;
  logic [bht_pkg::ROW_W-1:0]        ir_row_q;
  bht_pkg::row_vec_t                ir_loc_q;
  logic [1:0]                       k_q;

  logic                             par_ok, bone_ok, hazard, go, last_go, accept, pop;
  logic [BIDX_W-1:0]                par_idx;
  logic [CW-1:0]                    cred_q;

  // Combined table, one matrix row of four elements per entry.
  bht_pkg::row_vec_t                mem [DEPTH];
  bht_pkg::row_vec_t                rd_q, wdata;
  logic [AW-1:0]                    raddr, waddr;
  logic                             we;

  // Clearing pass after reset.
  logic                             clr_q;
  logic [AW-1:0]                    clr_cnt_q;

  // Write-back of a finished matrix from the staging rows.
  bht_pkg::row_vec_t                staging_q [4];
  logic                             wact_q;
  logic [1:0]                       wcnt_q;
  logic [bht_pkg::BONE_W-1:0]       wbone_q;

  // Beat pipeline: s1 = read data, s2 = products, s3 = accumulated sums.
  logic                             s1_v_q, s2_v_q, s3_v_q;
  bht_pkg::beat_t                   s1_meta_q, s2_meta_q, s3_meta_q;
  bht_pkg::elem_t                   s1_loc_q;
  logic                             s1_id_q;
  bht_pkg::row_vec_t                s1_par;
  bht_pkg::lane_ctl_t               lane_ctl;
  bht_pkg::acc_t                    acc [bht_pkg::NUM_LANES];

  bht_pkg::row_vec_t                comb;
  logic                             sat;
  bht_pkg::res_t                    push_data, q_data;

  // A parent outside 0..MAX_BONES-1 uses the identity matrix.
  assign par_ok  = !ir_par_q[bht_pkg::PAR_W-1] && (32'(ir_par_q[7:0]) < MAX_BONES);
  assign par_idx = BIDX_W'(ir_par_q[7:0]);
  assign bone_ok = 32'(ir_bone_q) < MAX_BONES;

  // Stall the first read while any pending write targets the parent.
  assign hazard = par_ok && (
      (s1_v_q && s1_meta_q.wr && (s1_meta_q.bone == ir_par_q[7:0])) ||
      (s2_v_q && s2_meta_q.wr && (s2_meta_q.bone == ir_par_q[7:0])) ||
      (s3_v_q && s3_meta_q.wr && (s3_meta_q.bone == ir_par_q[7:0])) ||
      (wact_q && (wbone_q == ir_par_q[7:0])));

  assign go      = ir_v_q && ((k_q != 2'd0) || !hazard);
  assign last_go = go && (k_q == 2'd3);
  assign pop     = out_valid_o && out_ready_i;

  // Credits bound the words in flight to the output queue depth.
  assign in_ready_o = !clr_q && (cred_q < CW'(bht_pkg::OQ_DEPTH)) && (!ir_v_q || last_go);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_v_q <= 1'b0;
      k_q    <= '0;
      cred_q <= '0;
    end else begin
      if (accept) begin
        ir_v_q <= 1'b1;
      end else if (last_go) begin
        ir_v_q <= 1'b0;
      end
      if (go) begin
        k_q <= k_q + 1'b1;
      end
      cred_q <= cred_q + CW'(accept) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ir_bone_q <= bone_index_i;
      ir_par_q  <= parent_index_i;
      ir_row_q  <= row_index_i;
      ir_loc_q  <= {local_e3_i, local_e2_i, local_e1_i, local_e0_i};
    end
  end

  // Table ports: the clearing pass and the write-back never overlap.
  assign raddr = {par_idx, k_q};
  assign we    = clr_q || wact_q;
  assign waddr = clr_q ? clr_cnt_q : {BIDX_W'(wbone_q), wcnt_q};
  assign wdata = clr_q ? ident_row(clr_cnt_q[1:0]) : staging_q[wcnt_q];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (go) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Advance the beat pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= go;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && (s2_meta_q.beat == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_meta_q.beat <= k_q;
      s1_meta_q.bone <= ir_bone_q;
      s1_meta_q.row  <= ir_row_q;
      s1_meta_q.fwd  <= $signed(ir_par_q) >= $signed({1'b0, ir_bone_q});
      s1_meta_q.wr   <= (ir_row_q == 2'd3) && bone_ok;
      s1_loc_q       <= ir_loc_q[k_q];
      s1_id_q        <= !par_ok;
    end
    s2_meta_q <= s1_meta_q;
    s3_meta_q <= s2_meta_q;
  end

  assign s1_par = s1_id_q ? ident_row(s1_meta_q.beat) : rd_q;

  assign lane_ctl.mul_en = s1_v_q;
  assign lane_ctl.acc_en = s2_v_q;
  assign lane_ctl.first  = (s2_meta_q.beat == 2'd0);

  // One lane per output column: lane j sums loc[k] * parent[k][j] over k.
  for (genvar j = 0; j < bht_pkg::NUM_LANES; j++) begin : g_lane
    bht_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (lane_ctl),
      .a_i   (s1_loc_q),
      .b_i   (bht_pkg::elem_t'(s1_par[j])),
      .acc_o (acc[j])
    );
  end

  bht_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .acc_i  (acc),
    .comb_o (comb),
    .sat_o  (sat)
  );

  assign push_data.bone  = s3_meta_q.bone;
  assign push_data.row   = s3_meta_q.row;
  assign push_data.elems = comb;
  assign push_data.fwd   = s3_meta_q.fwd;
  assign push_data.sat   = sat;

  // Stage every finished row; a row 3 of a bone below MAX_BONES starts the four-row write-back.
  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      staging_q[s3_meta_q.row] <= comb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wact_q  <= 1'b0;
      wcnt_q  <= '0;
      wbone_q <= '0;
    end else if (s3_v_q && s3_meta_q.wr) begin
      wact_q  <= 1'b1;
      wcnt_q  <= '0;
      wbone_q <= s3_meta_q.bone;
    end else if (wact_q) begin
      wcnt_q <= wcnt_q + 1'b1;
      if (wcnt_q == 2'd3) begin
        wact_q <= 1'b0;
      end
    end
  end

  bht_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_v_q),
    .data_i  (push_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (q_data)
  );

  assign out_bone_o       = q_data.bone;
  assign out_row_o        = q_data.row;
  assign comb_e0_o        = q_data.elems[0];
  assign comb_e1_o        = q_data.elems[1];
  assign comb_e2_o        = q_data.elems[2];
  assign comb_e3_o        = q_data.elems[3];
  assign forward_parent_o = q_data.fwd;
  assign saturated_o      = q_data.sat;

endmodule

### tb/bone_hierarchy_transform_tb.sv
module bone_hierarchy_transform_tb;

  localparam int BONE_W     = bht_pkg::BONE_W;
  localparam int PAR_W      = bht_pkg::PAR_W;
  localparam int ROW_W      = bht_pkg::ROW_W;
  localparam int ELEM_W     = bht_pkg::ELEM_W;
  localparam int ACC_W      = bht_pkg::ACC_W;
  localparam int BONES      = bht_pkg::MAX_BONES_DEF;
  localparam int FRAC       = bht_pkg::FRAC_BITS_DEF;
  localparam int RAND_WORDS = 1100;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 16;
  localparam int PRINT_CAP  = 50;

  // One input word: a row of a bone's local matrix.
  typedef struct packed {
    logic [BONE_W-1:0]        bone;
    logic signed [PAR_W-1:0]  parent;
    logic [ROW_W-1:0]         row;
    logic [3:0][ELEM_W-1:0]   loc;
  } joint_word_t;

  // One result word: a row of the combined matrix.
  typedef struct packed {
    logic [BONE_W-1:0]        bone;
    logic [ROW_W-1:0]         row;
    logic [3:0][ELEM_W-1:0]   comb;
    logic                     fwd;
    logic                     sat;
  } pose_row_t;

  // Directed row: typed marks rows whose result is the local row itself
  // (identity parent), with the forward flag written out by hand.
  typedef struct packed {
    joint_word_t word;
    logic        typed;
    logic        fwd;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [BONE_W-1:0] bone_index_i;
  logic signed [PAR_W-1:0] parent_index_i;
  logic [ROW_W-1:0] row_index_i;
  logic signed [ELEM_W-1:0] local_e0_i;
  logic signed [ELEM_W-1:0] local_e1_i;
  logic signed [ELEM_W-1:0] local_e2_i;
  logic signed [ELEM_W-1:0] local_e3_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [BONE_W-1:0] out_bone_o;
  logic [ROW_W-1:0] out_row_o;
  logic signed [ELEM_W-1:0] comb_e0_o;
  logic signed [ELEM_W-1:0] comb_e1_o;
  logic signed [ELEM_W-1:0] comb_e2_o;
  logic signed [ELEM_W-1:0] comb_e3_o;
  logic forward_parent_o;
  logic saturated_o;

  // Predictor state: combined matrices, staged rows and the staging bone.
  logic [ELEM_W-1:0] pose_mtx [BONES*16];
  logic [ELEM_W-1:0] stage_rows [16];
  logic [BONE_W-1:0] stage_bone;

  pose_row_t pending_rows [$];
  dir_row_t  dir_tab [$];

  int err_cnt     = 0;
  int checked_cnt = 0;
  int sat_cnt     = 0;
  int fwd_cnt     = 0;
  int words_in    = 0;
  int dir_words   = 0;
  int burst_left  = 0;
  int cycle_cnt   = 0;

  // Receiver stall state.
  int hold_cnt  = 0;
  int hold_idx  = 0;
  int rx_mode   = 0;
  int mode_left = 0;
  int rx_phase  = 0;

  bone_hierarchy_transform uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .bone_index_i     (bone_index_i),
    .parent_index_i   (parent_index_i),
    .row_index_i      (row_index_i),
    .local_e0_i       (local_e0_i),
    .local_e1_i       (local_e1_i),
    .local_e2_i       (local_e2_i),
    .local_e3_i       (local_e3_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_bone_o       (out_bone_o),
    .out_row_o        (out_row_o),
    .comb_e0_o        (comb_e0_o),
    .comb_e1_o        (comb_e1_o),
    .comb_e2_o        (comb_e2_o),
    .comb_e3_o        (comb_e3_o),
    .forward_parent_o (forward_parent_o),
    .saturated_o      (saturated_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Identity element at flat index k of a 4x4 matrix.
  function automatic logic [ELEM_W-1:0] unit_elem(input int k);
    return ((k >> 2) == (k & 3)) ? ELEM_W'(1 << FRAC) : '0;
  endfunction

  // Multiply one local row by the parent's stored matrix, floor the sum of the
  // exact products down by FRAC bits, clamp to 32 bits, stage the row and
  // commit the staged matrix on row 3.
  function automatic pose_row_t compose_row(input joint_word_t w);
    pose_row_t r;
    logic [ELEM_W-1:0] par [16];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] v;
    longint prod;
    int p;
    r.bone = w.bone;
    r.row  = w.row;
    r.sat  = 1'b0;
    p = int'($signed(w.parent));
    // Any negative parent, not just -1, falls back to the identity.
    for (int k = 0; k < 16; k++)
      par[k] = (p >= 0 && p < BONES) ? pose_mtx[p*16 + k] : unit_elem(k);
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        prod = longint'($signed(w.loc[k])) * longint'($signed(par[k*4 + j]));
        acc = acc + prod;
      end
      v = acc >>> FRAC;
      if (v > bht_pkg::SAT_HI) begin
        v = bht_pkg::SAT_HI;
        r.sat = 1'b1;
      end else if (v < bht_pkg::SAT_LO) begin
        v = bht_pkg::SAT_LO;
        r.sat = 1'b1;
      end
      r.comb[j] = v[ELEM_W-1:0];
      stage_rows[int'(w.row)*4 + j] = v[ELEM_W-1:0];
    end
    r.fwd = ($signed(w.parent) >= $signed({1'b0, w.bone}));
    // Row 3 commits all four staged rows to the bone of this word, whatever
    // bones supplied rows 0 to 2.
    stage_bone = w.bone;
    if (w.row == 2'd3)
      for (int k = 0; k < 16; k++)
        pose_mtx[int'(stage_bone)*16 + k] = stage_rows[k];
    return r;
  endfunction

  function automatic dir_row_t mk_dir(input int bone, input int parent, input int row,
                                      input logic [31:0] e0, input logic [31:0] e1,
                                      input logic [31:0] e2, input logic [31:0] e3,
                                      input bit typed, input bit fwd);
    dir_row_t d;
    d.word.bone   = BONE_W'(bone);
    d.word.parent = PAR_W'(parent);
    d.word.row    = ROW_W'(row);
    d.word.loc[0] = e0;
    d.word.loc[1] = e1;
    d.word.loc[2] = e2;
    d.word.loc[3] = e3;
    d.typed       = typed;
    d.fwd         = fwd;
    return d;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input dir_row_t d);
    dir_tab.insert(dir_tab.size(), d);
  endtask

  // Element generator: small values, full range, corner values, or a row
  // close to identity so that deep parent chains stay in range.
  function automatic logic [ELEM_W-1:0] rand_elem(input int cls, input bit diag);
    logic [ELEM_W-1:0] e;
    case (cls)
      0: e = ELEM_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      1: e = $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: e = 32'h7fff_ffff;
          1: e = 32'h8000_0000;
          2: e = 32'h0000_0000;
          3: e = 32'hffff_ffff;
          4: e = 32'h0001_0000;
          default: e = 32'hffff_0000;
        endcase
      end
      default: begin
        e = ELEM_W'(int'($urandom_range(0, 1 << 13)) - (1 << 12));
        if (diag)
          e = e + ELEM_W'(1 << FRAC);
      end
    endcase
    return e;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= PRINT_CAP)
      $display("mismatch %0d at result %0d, %s: got %h want %h",
               err_cnt, checked_cnt, field, got, want);
  endtask

  // Offer one word in bursts with random gaps, wait for the handshake,
  // then predict and queue its result.
  task automatic send_word(input joint_word_t w, input bit typed, input bit fwd);
    pose_row_t want;
    pose_row_t hand;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 7));
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = int'($urandom_range(1, 16));
    end
    @(negedge clk_i);
    bone_index_i   <= w.bone;
    parent_index_i <= w.parent;
    row_index_i    <= w.row;
    local_e0_i     <= w.loc[0];
    local_e1_i     <= w.loc[1];
    local_e2_i     <= w.loc[2];
    local_e3_i     <= w.loc[3];
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    words_in++;
    // Always run the predictor so its state tracks the block.
    want = compose_row(w);
    if (typed) begin
      hand.bone = w.bone;
      hand.row  = w.row;
      hand.comb = w.loc;
      hand.fwd  = fwd;
      hand.sat  = 1'b0;
      pending_rows.insert(pending_rows.size(), hand);
    end else begin
      pending_rows.insert(pending_rows.size(), want);
    end
  endtask

  // Compare each accepted result word with the oldest pending row.
  always @(posedge clk_i) begin
    pose_row_t got;
    pose_row_t want;
    if (out_valid_o && out_ready_i) begin
      got.bone    = out_bone_o;
      got.row     = out_row_o;
      got.comb[0] = comb_e0_o;
      got.comb[1] = comb_e1_o;
      got.comb[2] = comb_e2_o;
      got.comb[3] = comb_e3_o;
      got.fwd     = forward_parent_o;
      got.sat     = saturated_o;
      if (pending_rows.size() == 0) begin
        report_mismatch("word with nothing pending", 32'({out_bone_o, out_row_o}), '0);
      end else begin
        want = pending_rows.pop_front();
        if (got.bone != want.bone) report_mismatch("out_bone", 32'(got.bone), 32'(want.bone));
        if (got.row != want.row) report_mismatch("out_row", 32'(got.row), 32'(want.row));
        for (int j = 0; j < 4; j++)
          if (got.comb[j] != want.comb[j])
            report_mismatch($sformatf("comb_e%0d", j), got.comb[j], want.comb[j]);
        if (got.fwd != want.fwd)
          report_mismatch("forward_parent", 32'(got.fwd), 32'(want.fwd));
        if (got.sat != want.sat) report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
        if (want.sat) sat_cnt++;
        if (want.fwd) fwd_cnt++;
        checked_cnt++;
      end
    end
  end

  // Receiver: switch among stall patterns, and twice hold off for a long
  // stretch so the output queue fills and the block stalls its input.
  always @(negedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (hold_idx < 2 && words_in >= (hold_idx == 0 ? 300 : 800)) begin
      hold_cnt    <= HOLD_LEN;
      hold_idx    <= hold_idx + 1;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= int'($urandom_range(0, 3));
        mode_left <= int'($urandom_range(16, 128));
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 4) != 0);
        default: out_ready_i <= ((rx_phase % 5) < 2);
      endcase
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("timeout with %0d rows still pending", pending_rows.size());
      $display("bone_hierarchy_transform_tb failed");
      $finish;
    end
  end

  initial begin
    joint_word_t w;
    int bone;
    int par;
    int cls;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    bone_index_i   = '0;
    parent_index_i = '0;
    row_index_i    = '0;
    local_e0_i     = '0;
    local_e1_i     = '0;
    local_e2_i     = '0;
    local_e3_i     = '0;
    for (int k = 0; k < BONES*16; k++)
      pose_mtx[k] = unit_elem(k & 15);
    for (int k = 0; k < 16; k++)
      stage_rows[k] = '0;
    stage_bone = '0;

    // Directed rows. Bone 0 goes first as a full root matrix so every staging
    // slot is written before any later row 3.
    add_row(mk_dir(0, -1, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                   1'b1, 1'b0));
    add_row(mk_dir(0, -1, 1, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b1, 1'b0));
    add_row(mk_dir(0, -1, 2, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b1, 1'b0));
    add_row(mk_dir(0, -1, 3, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000,
                   32'h0001_0000, 1'b1, 1'b0));
    // Child of bone 0: large rows against a matrix holding the extremes.
    add_row(mk_dir(1, 0, 0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
    add_row(mk_dir(1, 0, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 1'b0, 1'b0));
    add_row(mk_dir(1, 0, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 1'b0, 1'b0));
    add_row(mk_dir(1, 0, 3, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0, 1'b0));
    // Self, forward and odd negative parents against identity entries.
    add_row(mk_dir(2, 2, 0, 32'h1234_5678, 32'hedcb_a988, 32'h0000_0001,
                   32'hffff_fffe, 1'b1, 1'b1));
    add_row(mk_dir(2, 5, 1, 32'h0003_0000, 32'h0, 32'hfff8_0000, 32'h0, 1'b1, 1'b1));
    add_row(mk_dir(2, -256, 2, 32'h0, 32'h0004_0000, 32'h0001_0000, 32'h0, 1'b1, 1'b0));
    add_row(mk_dir(2, -2, 3, 32'h0000_4000, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b0));
    // Self parent with a stored matrix: the old one is used until row 3.
    add_row(mk_dir(2, 2, 0, 32'h0001_8000, 32'h0000_1000, 32'hffff_0000,
                   32'h0, 1'b0, 1'b0));
    add_row(mk_dir(2, 2, 3, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000, 1'b0, 1'b0));
    // Highest bone, then mixed bones committing to the bone of row 3.
    add_row(mk_dir(255, 255, 0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
                   1'b1, 1'b1));
    add_row(mk_dir(3, 1, 3, 32'h0000_0100, 32'hffff_ff00, 32'h0, 32'h0001_0000,
                   1'b0, 1'b0));
    add_row(mk_dir(255, 3, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 1'b0, 1'b0));
    add_row(mk_dir(0, 255, 2, 32'hffff_ffff, 32'h0, 32'h7fff_ffff, 32'h1, 1'b0, 1'b0));
    add_row(mk_dir(255, -1, 3, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                   32'h0, 1'b1, 1'b0));
    add_row(mk_dir(4, 255, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 1'b0, 1'b0));

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i])
      send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].fwd);
    dir_words = words_in;

    // Random part: mostly whole matrices sent in row order, some noise words.
    while (words_in < dir_words + RAND_WORDS) begin
      if ($urandom_range(0, 9) < 8) begin
        bone = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                           : int'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
          0, 1: par = -1;
          2, 3, 4, 5: par = (bone > 0) ? int'($urandom_range(0, bone - 1)) : -1;
          6: par = int'($urandom_range(bone, 255));
          default: par = -int'($urandom_range(2, 256));
        endcase
        cls = int'($urandom_range(0, 4));
        for (int r = 0; r < 4; r++) begin
          w.bone   = BONE_W'(bone);
          w.parent = PAR_W'(par);
          w.row    = ROW_W'(r);
          for (int k = 0; k < 4; k++)
            w.loc[k] = rand_elem(($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 3))
                                                               : cls,
                                 k == r);
          send_word(w, 1'b0, 1'b0);
        end
      end else begin
        w.bone   = BONE_W'($urandom);
        w.parent = PAR_W'($urandom);
        w.row    = ROW_W'($urandom);
        for (int k = 0; k < 4; k++)
          w.loc[k] = rand_elem(int'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        send_word(w, 1'b0, 1'b0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then give stray words time to show up.
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("sent %0d words (%0d directed), checked %0d results", words_in, dir_words,
             checked_cnt);
    $display("%0d results clamped, %0d with forward or self parent, %0d mismatches",
             sat_cnt, fwd_cnt, err_cnt);
    if (err_cnt == 0)
      $display("bone_hierarchy_transform_tb passed");
    else
      $display("bone_hierarchy_transform_tb failed");
    $finish;
  end

endmodule
